// ----- design/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion shorthands shared by the projection oscillator RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PRJ_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PRJ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- design/prjosc_pkg.sv -----
// ----------------------------------------------------------------------------
// prjosc_pkg
// Shared types, constants and tables of the projection oscillator.
// ----------------------------------------------------------------------------
package prjosc_pkg;

	localparam int MAX_WINDOW_DEF = 64;
	localparam int PRICE_BITS_DEF = 32;

	localparam int WIN_W         = 7;
	localparam int SMOOTH_W      = 11;
	localparam int WINDOW_RESET  = 10;
	localparam int SMOOTH_RESET  = 5;
	localparam int OSC_W         = 32;
	localparam int OSC_FRAC      = 16;
	localparam int OSC_SCALE     = 100;
	localparam int CFG_IDX_W     = 8;
	localparam int CFG_DATA_W    = 16;
	localparam int SLOPE_DEN_W   = 4 * WIN_W;

	localparam logic [CFG_IDX_W-1:0] REG_WINDOW = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_SMOOTH = CFG_IDX_W'(1);

	localparam logic signed [OSC_W-1:0] OSC_MAX = {1'b0, {(OSC_W-1){1'b1}}};
	localparam logic signed [OSC_W-1:0] OSC_MIN = {1'b1, {(OSC_W-1){1'b0}}};

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_WSUM,
		ST_NUM1,
		ST_NUM2,
		ST_NUM3,
		ST_DIVB,
		ST_WALK,
		ST_OSC1,
		ST_OSC2,
		ST_DIVO,
		ST_EMA,
		ST_DIVE,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

	// Regression denominator n*n*(n*n-1)/12 for every window length.
	function automatic logic [SLOPE_DEN_W-1:0] slope_den(input logic [WIN_W-1:0] n);
		logic [SLOPE_DEN_W-1:0] r;
		r = '0;
		for (int k = 1; k < 2**WIN_W; k++) begin
			if (int'(n) == k) begin
				r = SLOPE_DEN_W'((k * k * (k * k - 1)) / 12);
			end
		end
		return r;
	endfunction

endpackage

// ----- design/prjosc_ifs.sv -----
// ----------------------------------------------------------------------------
// Projection oscillator channels
// Sample input, result output and register write channels.
// ----------------------------------------------------------------------------
interface prjosc_in_if #(
	parameter int PRICE_BITS = prjosc_pkg::PRICE_BITS_DEF
);
	logic                  valid;
	logic                  ready;
	logic [PRICE_BITS-1:0] high;
	logic [PRICE_BITS-1:0] low;
	logic [PRICE_BITS-1:0] close;

	modport source (output valid, high, low, close, input ready);
	modport sink   (input valid, high, low, close, output ready);
endinterface

interface prjosc_out_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [prjosc_pkg::OSC_W-1:0]  oscillator;
	logic                                 divide_fault;

	modport source (output valid, oscillator, divide_fault, input ready);
	modport sink   (input valid, oscillator, divide_fault, output ready);
endinterface

interface prjosc_cfg_if;
	logic                              valid;
	logic                              ready;
	logic [prjosc_pkg::CFG_IDX_W-1:0]  index;
	logic [prjosc_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

// ----- design/prjosc_hist_mem.sv -----
// ----------------------------------------------------------------------------
// prjosc_hist_mem
// Sample history: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module prjosc_hist_mem #(
	parameter int DEPTH = prjosc_pkg::MAX_WINDOW_DEF,
	parameter int WIDTH = 3 * prjosc_pkg::PRICE_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- design/prjosc_div.sv -----
// ----------------------------------------------------------------------------
// prjosc_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module prjosc_div #(
	parameter int NW = 75,
	parameter int DW = 53
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [NW-1:0]         num,
	input  logic [DW-1:0]         den,
	output logic [NW-1:0]         quot,
	output prjosc_pkg::div_stat_t stat
);
	import prjosc_pkg::*;

	localparam int CW = $clog2(NW + 1);

	logic [DW-1:0] rem_q;
	logic [DW-1:0] den_q;
	logic [NW-1:0] quo_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [DW:0]   trial;
	logic [DW:0]   diff;
	logic          take;

	// The shift register holds the unconsumed numerator bits on top and the
	// quotient bits collected so far below them.
	assign trial = {rem_q, quo_q[NW-1]};
	assign diff  = trial - {1'b0, den_q};
	assign take  = (trial >= {1'b0, den_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			den_q <= den;
			quo_q <= num;
		end else if (busy_q) begin
			rem_q <= take ? diff[DW-1:0] : trial[DW-1:0];
			quo_q <= {quo_q[NW-2:0], take};
		end
	end

	assign quot      = quo_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

// ----- design/projected_oscillator.sv -----
// ----------------------------------------------------------------------------
// projected_oscillator
// Projection oscillator with exponential smoothing over high/low/close words.
// ----------------------------------------------------------------------------
// Usage: each word on the samples channel carries one high, low and close
// price (unsigned Q16.16). The first window_length-1 words after reset or a
// register write produce no result; every later word produces one word on
// the results channel: the oscillator (signed Q16.16 percent, saturating),
// raw for the first result and smoothed afterwards, plus a divide fault flag.
// Registers are written over the cfg channel, which is taken only while the
// block is idle; a write to the window or smoothing register restarts the
// running sums and the smoothing. A result word waits on the bit-serial
// divider (DIV_NW is 75 with the default parameters), which computes slope,
// ratio and smoothing step in turn where needed, and on the walk through the
// history memory at one entry a cycle. One word is in work at a time.
// Reset clears the sums and restores the register defaults; the history
// memory is not cleared and needs no clearing pass.
// The result sits in an output register; while the receiver stalls, the
// block finishes its current word and then waits before storing the next.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module projected_oscillator #(
	parameter int MAX_WINDOW = prjosc_pkg::MAX_WINDOW_DEF,
	parameter int PRICE_BITS = prjosc_pkg::PRICE_BITS_DEF
) (
	input logic        clk,
	input logic        arst_n,
	prjosc_in_if.sink  samples,
	prjosc_out_if.source results,
	prjosc_cfg_if.sink cfg
);
	import prjosc_pkg::*;

	localparam int LOGW   = $clog2(MAX_WINDOW + 1);
	localparam int AW     = $clog2(MAX_WINDOW);
	localparam int WM_W   = LOGW + 1;
	localparam int CS_W   = PRICE_BITS + LOGW;
	localparam int WS_W   = PRICE_BITS + 2 * LOGW;
	localparam int T_W    = 2 * LOGW;
	localparam int NUM_W  = WS_W + LOGW + 1;
	localparam int B_W    = PRICE_BITS + 11;
	localparam int JB_W   = B_W + LOGW;
	localparam int PJ_W   = JB_W + 1;
	localparam int DIFF_W = PJ_W + 1;
	localparam int EW     = OSC_W + 3;
	localparam int ENT_W  = 3 * PRICE_BITS;
	localparam int SN_W   = NUM_W + 8;
	localparam int ON_W   = DIFF_W + 23;
	localparam int NW_A   = (SN_W > ON_W) ? SN_W : ON_W;
	localparam int DIV_NW = (NW_A > EW + 1) ? NW_A : EW + 1;
	localparam int DW_A   = (DIFF_W > SLOPE_DEN_W) ? DIFF_W : SLOPE_DEN_W;
	localparam int DIV_DW = (DW_A > SMOOTH_W + 1) ? DW_A : SMOOTH_W + 1;

	function automatic logic [LOGW-1:0] eff_win(input logic [WIN_W-1:0] w);
		logic [LOGW-1:0] r;
		if (w == '0) begin
			r = LOGW'(1);
		end else if (int'(w) > MAX_WINDOW) begin
			r = LOGW'(MAX_WINDOW);
		end else begin
			r = LOGW'(w);
		end
		return r;
	endfunction

	function automatic logic [WM_W-1:0] warm_init(input logic [LOGW-1:0] n);
		return WM_W'(1) - WM_W'(n);
	endfunction

	// Control state.
	state_t                    state_q, state_d;
	logic [WIN_W-1:0]          win_q;
	logic [SMOOTH_W-1:0]       smooth_q;
	logic [AW-1:0]             wptr_q;
	logic [CS_W-1:0]           cs_q;
	logic [WS_W-1:0]           wsum_q;
	logic signed [WM_W-1:0]    warm_q;
	logic signed [OSC_W-1:0]   sm_q;
	logic                      v_s1, v_s2;
	logic                      out_valid_q;

	// Per-word datapath.
	logic [AW-1:0]             cur_q;
	logic [PRICE_BITS-1:0]     h_q, l_q, c_q, oldest_q;
	logic signed [NUM_W-1:0]   t1_q, t2_q, num_q;
	logic signed [B_W-1:0]     b_q;
	logic [LOGW-1:0]           rd_j_q;
	logic signed [JB_W-1:0]    jb_iss_q, jb_s1;
	logic                      last_s1;
	logic signed [PJ_W-1:0]    ph_s2, pl_s2, pmax_q, pmin_q;
	logic signed [DIFF_W-1:0]  dn_q, dd_q;
	logic                      neg_q;
	logic signed [OSC_W-1:0]   osc_q, val_q, out_osc_q;
	logic                      fault_q, out_fault_q;

	// Combinational helpers.
	logic                      in_acc, cfg_acc, fin_go, iss, walk_end, warm_neg;
	logic [LOGW-1:0]           n_eff, weight;
	logic [T_W-1:0]            tri_n;
	logic [SLOPE_DEN_W-1:0]    den_n;
	logic [WS_W-1:0]           wprod;
	logic [LOGW:0]             back_diff;
	logic [AW-1:0]             rd_idx;
	logic [ENT_W-1:0]          mem_rdata;
	logic [PRICE_BITS-1:0]     mem_h, mem_l, mem_c;
	logic [NUM_W-1:0]          num_mag;
	logic [DIFF_W-1:0]         dn_mag, dd_mag;
	logic signed [EW-1:0]      delta, dbl;
	logic [EW-1:0]             ema_mag;
	logic [SMOOTH_W:0]         len1;
	logic                      div_start;
	logic [DIV_NW-1:0]         div_num, div_quot;
	logic [DIV_DW-1:0]         div_den;
	div_stat_t                 div_stat;
	logic [OSC_W-1:0]          q_osc;
	logic [EW-1:0]             q_ema;
	logic [B_W-1:0]            q_b;
	logic                      osc_sat;

	assign in_acc   = samples.valid && samples.ready;
	assign cfg_acc  = cfg.valid && cfg.ready;
	assign n_eff    = eff_win(win_q);
	assign warm_neg = warm_q[WM_W-1];
	assign weight   = warm_neg ? LOGW'(warm_q + WM_W'(n_eff)) : n_eff;
	assign wprod    = WS_W'(c_q) * WS_W'(weight);
	assign tri_n    = T_W'((T_W'(n_eff) * (T_W'(n_eff) + T_W'(1))) >> 1);
	assign den_n    = slope_den(WIN_W'(n_eff));
	assign iss      = (rd_j_q < n_eff);
	assign walk_end = !iss && !v_s1 && !v_s2;
	assign fin_go   = (state_q == ST_FINISH) && (!out_valid_q || results.ready);

	// History index of age rd_j, wrapping around the ring.
	assign back_diff = {1'b0, LOGW'(cur_q)} - {1'b0, rd_j_q};
	assign rd_idx    = back_diff[LOGW] ? AW'(back_diff + (LOGW+1)'(MAX_WINDOW))
	                                   : AW'(back_diff);

	assign mem_h = mem_rdata[3*PRICE_BITS-1:2*PRICE_BITS];
	assign mem_l = mem_rdata[2*PRICE_BITS-1:PRICE_BITS];
	assign mem_c = mem_rdata[PRICE_BITS-1:0];

	// Divider operand shaping.
	assign num_mag = num_q[NUM_W-1] ? NUM_W'(-num_q) : NUM_W'(num_q);
	assign dn_mag  = dn_q[DIFF_W-1] ? DIFF_W'(-dn_q) : DIFF_W'(dn_q);
	assign dd_mag  = dd_q[DIFF_W-1] ? DIFF_W'(-dd_q) : DIFF_W'(dd_q);
	assign delta   = EW'(osc_q) - EW'(sm_q);
	assign dbl     = delta <<< 1;
	assign ema_mag = dbl[EW-1] ? EW'(-dbl) : EW'(dbl);
	assign len1    = (smooth_q == '0) ? (SMOOTH_W+1)'(2) : ((SMOOTH_W+1)'(smooth_q) + 1'b1);

	assign q_b     = div_quot[B_W-1:0];
	assign q_osc   = div_quot[OSC_W-1:0];
	assign q_ema   = div_quot[EW-1:0];
	assign osc_sat = |div_quot[DIV_NW-1:OSC_W-1];

	prjosc_hist_mem #(
		.DEPTH (MAX_WINDOW),
		.WIDTH (ENT_W)
	) u_mem (
		.clk   (clk),
		.we    (in_acc),
		.waddr (wptr_q),
		.wdata ({samples.high, samples.low, samples.close}),
		.raddr (rd_idx),
		.rdata (mem_rdata)
	);

	prjosc_div #(
		.NW (DIV_NW),
		.DW (DIV_DW)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.quot   (div_quot),
		.stat   (div_stat)
	);

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:   if (in_acc) state_d = ST_WSUM;
			ST_WSUM:   state_d = warm_neg ? ST_IDLE : ST_NUM1;
			ST_NUM1:   state_d = ST_NUM2;
			ST_NUM2:   state_d = ST_NUM3;
			ST_NUM3:   state_d = (den_n != '0) ? ST_DIVB : ST_WALK;
			ST_DIVB:   if (div_stat.done) state_d = ST_WALK;
			ST_WALK:   if (walk_end) state_d = ST_OSC1;
			ST_OSC1:   state_d = ST_OSC2;
			ST_OSC2:   state_d = div_start ? ST_DIVO : ST_EMA;
			ST_DIVO:   if (div_stat.done) state_d = ST_EMA;
			ST_EMA:    state_d = div_start ? ST_DIVE : ST_FINISH;
			ST_DIVE:   if (div_stat.done) state_d = ST_FINISH;
			ST_FINISH: if (fin_go) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// Handshakes and divider requests.
	always_comb begin
		cfg.ready     = (state_q == ST_IDLE);
		samples.ready = (state_q == ST_IDLE) && !cfg.valid;
		div_start     = 1'b0;
		div_num       = '0;
		div_den       = '0;
		unique case (state_q)
			ST_NUM3: begin
				div_start = (den_n != '0);
				div_num   = DIV_NW'({num_mag, 8'h00}) + DIV_NW'(den_n >> 1);
				div_den   = DIV_DW'(den_n);
			end
			ST_OSC2: begin
				div_start = (dn_q != '0) && (dd_q != '0);
				div_num   = (DIV_NW'(dn_mag) * DIV_NW'(OSC_SCALE)) << OSC_FRAC;
				div_den   = DIV_DW'(dd_mag);
			end
			ST_EMA: begin
				div_start = (warm_q != '0);
				div_num   = DIV_NW'(ema_mag) + DIV_NW'(len1 >> 1);
				div_den   = DIV_DW'(len1);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			win_q       <= WIN_W'(WINDOW_RESET);
			smooth_q    <= SMOOTH_W'(SMOOTH_RESET);
			wptr_q      <= '0;
			cs_q        <= '0;
			wsum_q      <= '0;
			warm_q      <= warm_init(eff_win(WIN_W'(WINDOW_RESET)));
			sm_q        <= '0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			v_s1    <= (state_q == ST_WALK) && iss;
			v_s2    <= v_s1;
			if (cfg_acc) begin
				if (cfg.index == REG_WINDOW) begin
					win_q  <= cfg.data[WIN_W-1:0];
					warm_q <= warm_init(eff_win(cfg.data[WIN_W-1:0]));
					cs_q   <= '0;
					wsum_q <= '0;
					sm_q   <= '0;
				end else if (cfg.index == REG_SMOOTH) begin
					smooth_q <= cfg.data[SMOOTH_W-1:0];
					warm_q   <= warm_init(n_eff);
					cs_q     <= '0;
					wsum_q   <= '0;
					sm_q     <= '0;
				end
			end
			if (in_acc) begin
				wptr_q <= (wptr_q == AW'(MAX_WINDOW - 1)) ? '0 : wptr_q + 1'b1;
				cs_q   <= cs_q + CS_W'(samples.close);
			end
			if (state_q == ST_WSUM) begin
				wsum_q <= wsum_q + wprod;
				if (warm_neg) begin
					warm_q <= warm_q + WM_W'(1);
				end
			end
			if (fin_go) begin
				sm_q   <= val_q;
				warm_q <= WM_W'(1);
				wsum_q <= wsum_q - WS_W'(cs_q);
				cs_q   <= cs_q - CS_W'(oldest_q);
			end
			if (fin_go) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			h_q      <= samples.high;
			l_q      <= samples.low;
			c_q      <= samples.close;
			oldest_q <= samples.close;
			cur_q    <= wptr_q;
			pmax_q   <= PJ_W'({samples.high, 8'h00});
			pmin_q   <= PJ_W'({samples.low, 8'h00});
		end
		// Walk pipeline: issue, memory data, projection, compare.
		if (v_s1) begin
			ph_s2 <= PJ_W'({mem_h, 8'h00}) + PJ_W'(jb_s1);
			pl_s2 <= PJ_W'({mem_l, 8'h00}) + PJ_W'(jb_s1);
			if (last_s1) begin
				oldest_q <= mem_c;
			end
		end
		if (v_s2) begin
			if (ph_s2 > pmax_q) pmax_q <= ph_s2;
			if (pl_s2 < pmin_q) pmin_q <= pl_s2;
		end
		unique case (state_q)
			ST_NUM1: begin
				t1_q <= NUM_W'(wsum_q) * NUM_W'(n_eff);
				t2_q <= NUM_W'(cs_q) * NUM_W'(tri_n);
			end
			ST_NUM2: begin
				num_q <= t1_q - t2_q;
			end
			ST_NUM3: begin
				neg_q    <= num_q[NUM_W-1];
				b_q      <= '0;
				rd_j_q   <= LOGW'(1);
				jb_iss_q <= '0;
			end
			ST_DIVB: begin
				if (div_stat.done) begin
					b_q <= neg_q ? $signed(B_W'(-q_b)) : $signed(q_b);
				end
			end
			ST_WALK: begin
				if (iss) begin
					rd_j_q   <= rd_j_q + 1'b1;
					jb_iss_q <= jb_iss_q + JB_W'(b_q);
					jb_s1    <= jb_iss_q + JB_W'(b_q);
					last_s1  <= (rd_j_q == n_eff - 1'b1);
				end
			end
			ST_OSC1: begin
				dn_q <= DIFF_W'($signed({1'b0, c_q, 8'h00})) - DIFF_W'(pmin_q);
				dd_q <= DIFF_W'(pmax_q) - DIFF_W'(pmin_q);
			end
			ST_OSC2: begin
				neg_q   <= dn_q[DIFF_W-1] ^ dd_q[DIFF_W-1];
				osc_q   <= '0;
				// Close at the minimum is a plain zero; a flat band is a fault.
				fault_q <= (dn_q != '0) && (dd_q == '0);
			end
			ST_DIVO: begin
				if (div_stat.done) begin
					if (osc_sat) begin
						osc_q <= neg_q ? OSC_MIN : OSC_MAX;
					end else begin
						osc_q <= neg_q ? $signed(OSC_W'(-q_osc)) : $signed(q_osc);
					end
				end
			end
			ST_EMA: begin
				neg_q <= dbl[EW-1];
				val_q <= osc_q;
			end
			ST_DIVE: begin
				if (div_stat.done) begin
					val_q <= OSC_W'(EW'(sm_q) + (neg_q ? EW'(-q_ema) : q_ema));
				end
			end
			ST_FINISH: begin
				if (fin_go) begin
					out_osc_q   <= val_q;
					out_fault_q <= fault_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign results.valid        = out_valid_q;
	assign results.oscillator   = out_osc_q;
	assign results.divide_fault = out_fault_q;

	`PRJ_ASSERT_NEXT(a_accept_leaves_idle, clk, arst_n, in_acc, state_q == ST_WSUM, "accepted word did not start work")
	`PRJ_ASSERT_SAME(a_div_not_busy, clk, arst_n, div_start, !div_stat.busy, "divider restarted while busy")
	`PRJ_ASSERT_SAME(a_walk_contained, clk, arst_n, v_s2, state_q == ST_WALK, "walk pipeline active outside the walk")

endmodule

// ----- bench/testbench.sv -----
// ----------------------------------------------------------------------------
// Projection oscillator testbench
// Drives high/low/close words into projected_oscillator under several idle
// and stall mixes and register settings. Every result word is checked field
// by field, against values set in the plan for typed steps and otherwise
// against an in-bench model of slope, projection, ratio and smoothing.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import prjosc_pkg::*;

	localparam int HIST_DEPTH  = 64;
	localparam int SETTLE_CYC  = 400;
	localparam longint LIMIT   = 3000000;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = CFG_IDX_W'(2);

	typedef enum logic {STEP_CFG, STEP_SAMPLE} step_kind_t;

	typedef struct {
		logic signed [OSC_W-1:0] osc;
		logic                    fault;
	} osc_word_t;

	typedef struct {
		step_kind_t             kind;
		logic [CFG_IDX_W-1:0]   index;
		logic [CFG_DATA_W-1:0]  data;
		logic [31:0]            high;
		logic [31:0]            low;
		logic [31:0]            close;
		bit                     typed;
		logic signed [OSC_W-1:0] osc;
		logic                   fault;
	} step_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	always #2 clk = ~clk;

	prjosc_in_if  samples();
	prjosc_out_if results();
	prjosc_cfg_if cfg();

	projected_oscillator dut (
		.clk(clk), .arst_n(arst_n), .samples(samples), .results(results), .cfg(cfg)
	);

	// Shadow state of the block.
	logic [31:0] high_hist [HIST_DEPTH];
	logic [31:0] low_hist [HIST_DEPTH];
	logic [31:0] close_hist [HIST_DEPTH];
	longint window_reg, smooth_reg, close_total, weighted_total;
	logic signed [OSC_W-1:0] ema_state;
	int warmup, ring_ptr;

	osc_word_t pending_results[$];
	int errors = 0;
	int idle_pct = 0;
	int stall_pct = 0;
	longint cycles = 0;

	task automatic report(input string what);
		errors++;
		$display("MISMATCH at cycle %0d: %s", cycles, what);
	endtask

	function automatic longint eff_window();
		if (window_reg < 1) return 1;
		if (window_reg > HIST_DEPTH) return HIST_DEPTH;
		return window_reg;
	endfunction

	function automatic void restart_stream();
		close_total = 0;
		weighted_total = 0;
		ema_state = '0;
		warmup = int'(1 - eff_window());
	endfunction

	function automatic void write_register(input logic [CFG_IDX_W-1:0] index,
			input logic [CFG_DATA_W-1:0] data);
		if (index == REG_WINDOW) begin
			window_reg = longint'(data & 16'h7F);
		end else if (index == REG_SMOOTH) begin
			smooth_reg = longint'(data & 16'h7FF);
		end else begin
			return;
		end
		restart_stream();
	endfunction

	// Rounds to nearest with ties away from zero; den is positive.
	function automatic longint round_div(input longint num, input longint den);
		if (num >= 0) return (num + den / 2) / den;
		return -((-num + den / 2) / den);
	endfunction

	// Q16.16 quotient truncated toward zero, saturated to 32 bits.
	function automatic logic signed [OSC_W-1:0] ratio_q16(input longint num, input longint den);
		bit neg;
		longint unsigned un, ud, q, r;
		neg = (num < 0) != (den < 0);
		un = num < 0 ? -num : num;
		ud = den < 0 ? -den : den;
		q = un / ud;
		r = un % ud;
		if (q >= 32768) return neg ? OSC_MIN : OSC_MAX;
		for (int k = 0; k < 16; k++) begin
			r = r << 1;
			q = q << 1;
			if (r >= ud) begin
				r = r - ud;
				q = q | 1;
			end
		end
		return neg ? OSC_W'(-longint'(q)) : OSC_W'(q);
	endfunction

	function automatic bit predict_oscillator(input logic [31:0] h, input logic [31:0] l,
			input logic [31:0] c, output osc_word_t word);
		longint n, num, den, slope, pmax, pmin, cs, osc, ph, pl, len;
		int cur, idx;
		bit fault;
		n = eff_window();
		cur = ring_ptr;
		high_hist[cur] = h;
		low_hist[cur] = l;
		close_hist[cur] = c;
		ring_ptr = (cur + 1) % HIST_DEPTH;
		close_total += longint'(c);
		word = '{osc: '0, fault: 1'b0};
		if (warmup < 0) begin
			weighted_total += longint'(c) * (warmup + n);
			warmup++;
			return 0;
		end
		weighted_total += longint'(c) * n;
		slope = 0;
		den = n * n * (n * n - 1) / 12;
		if (den > 0) begin
			num = n * weighted_total - (n * (n + 1) / 2) * close_total;
			slope = round_div(num * 256, den);
		end
		pmax = longint'(h) * 256;
		pmin = longint'(l) * 256;
		for (longint j = 1; j < n; j++) begin
			idx = int'((cur + HIST_DEPTH - j) % HIST_DEPTH);
			ph = longint'(high_hist[idx]) * 256 + j * slope;
			pl = longint'(low_hist[idx]) * 256 + j * slope;
			if (ph > pmax) pmax = ph;
			if (pl < pmin) pmin = pl;
		end
		cs = longint'(c) * 256;
		fault = 1'b0;
		if (cs == pmin) begin
			osc = 0;
		end else if (pmax == pmin) begin
			osc = 0;
			fault = 1'b1;
		end else begin
			osc = longint'(ratio_q16((cs - pmin) * 100, pmax - pmin));
		end
		if (warmup == 0) begin
			word.osc = OSC_W'(osc);
		end else begin
			len = smooth_reg < 1 ? 1 : smooth_reg;
			word.osc = OSC_W'(longint'(ema_state) + round_div((osc - longint'(ema_state)) * 2,
				len + 1));
		end
		word.fault = fault;
		ema_state = word.osc;
		warmup = 1;
		weighted_total -= close_total;
		close_total -= longint'(close_hist[int'((cur + HIST_DEPTH - (n - 1)) % HIST_DEPTH)]);
		return 1;
	endfunction

	// Sender side: valid is left high after a word so back-to-back words need no
	// second assignment in one time step.
	task automatic send_sample(input logic [31:0] h, input logic [31:0] l, input logic [31:0] c,
			input bit typed, input osc_word_t typed_word);
		osc_word_t word;
		if ($urandom_range(99) < idle_pct) begin
			samples.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < idle_pct);
		end
		samples.valid <= 1'b1;
		samples.high <= h;
		samples.low <= l;
		samples.close <= c;
		do @(posedge clk); while (!samples.ready);
		if (predict_oscillator(h, l, c, word)) begin
			pending_results.push_back(typed ? typed_word : word);
		end
	endtask

	task automatic settle();
		samples.valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	task automatic write_cfg(input logic [CFG_IDX_W-1:0] index, input logic [CFG_DATA_W-1:0] data);
		settle();
		cfg.valid <= 1'b1;
		cfg.index <= index;
		cfg.data <= data;
		do @(posedge clk); while (!cfg.ready);
		write_register(index, data);
		cfg.valid <= 1'b0;
		@(posedge clk);
	endtask

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	always @(posedge clk) begin
		results.ready <= ($urandom_range(99) >= stall_pct);
	end

	always @(posedge clk) begin
		osc_word_t want;
		if (arst_n && results.valid && results.ready) begin
			if (pending_results.size() == 0) begin
				report($sformatf("unexpected word osc=%h fault=%b",
					results.oscillator, results.divide_fault));
			end else begin
				want = pending_results.pop_front();
				if (results.oscillator !== want.osc)
					report($sformatf("oscillator %h, expected %h", results.oscillator, want.osc));
				if (results.divide_fault !== want.fault)
					report($sformatf("divide_fault %b, expected %b",
						results.divide_fault, want.fault));
			end
		end
	end

	function automatic logic [31:0] pick_price(input logic [31:0] base);
		case ($urandom_range(15))
			0: return '0;
			1: return '1;
			2, 3: return $urandom;
			default: return base + 32'($urandom_range(65535)) - 32'd32768;
		endcase
	endfunction

	initial begin
		step_t plan[$];
		osc_word_t typed_word;
		logic [31:0] base, h, l, c;
		int win, sm, nitems;
		int modes_idle[4] = '{0, 87, 0, 37};
		int modes_stall[4] = '{0, 0, 87, 37};

		samples.valid = 1'b0;
		samples.high = '0;
		samples.low = '0;
		samples.close = '0;
		cfg.valid = 1'b0;
		cfg.index = '0;
		cfg.data = '0;
		window_reg = WINDOW_RESET;
		smooth_reg = SMOOTH_RESET;
		ring_ptr = 0;
		restart_stream();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// With a window of one and smoothing of one, every word is the raw ratio.
		plan.push_back('{STEP_CFG, REG_WINDOW, 16'd1, 0, 0, 0, 0, 0, 0});
		plan.push_back('{STEP_CFG, REG_SMOOTH, 16'd1, 0, 0, 0, 0, 0, 0});
		plan.push_back('{STEP_SAMPLE, 0, 0, 32'h0, 32'h0, 32'h0, 1, 0, 0});
		plan.push_back('{STEP_SAMPLE, 0, 0, '1, '1, '1, 1, 0, 0});
		plan.push_back('{STEP_SAMPLE, 0, 0, 32'd5, 32'd5, 32'd9, 1, 0, 1});
		plan.push_back('{STEP_SAMPLE, 0, 0, 32'h20000, 32'h0, 32'h20000, 1, 32'd6553600, 0});
		plan.push_back('{STEP_SAMPLE, 0, 0, 32'h20000, 32'h0, 32'h10000, 1, 32'd3276800, 0});
		plan.push_back('{STEP_SAMPLE, 0, 0, '1, 32'h0, '1, 1, 32'd6553600, 0});
		plan.push_back('{STEP_SAMPLE, 0, 0, 32'h1, 32'h0, '1, 1, OSC_MAX, 0});
		plan.push_back('{STEP_SAMPLE, 0, 0, 32'h0, 32'h1, '1, 1, OSC_MIN, 0});
		// High below low and close below low give signed ratios.
		plan.push_back('{STEP_SAMPLE, 0, 0, 32'h10000, 32'h20000, 32'h0, 1, 32'd13107200, 0});
		plan.push_back('{STEP_SAMPLE, 0, 0, 32'h20000, 32'h10000, 32'h0, 1, -32'sd6553600, 0});
		plan.push_back('{STEP_CFG, REG_WINDOW, 16'd0, 0, 0, 0, 0, 0, 0});
		plan.push_back('{STEP_CFG, REG_SMOOTH, 16'd0, 0, 0, 0, 0, 0, 0});
		plan.push_back('{STEP_SAMPLE, 0, 0, 32'h30000, 32'h10000, 32'h18000, 0, 0, 0});
		plan.push_back('{STEP_SAMPLE, 0, 0, 32'h30000, 32'h10000, 32'h28000, 0, 0, 0});
		plan.push_back('{STEP_CFG, REG_WINDOW, 16'd127, 0, 0, 0, 0, 0, 0});
		plan.push_back('{STEP_CFG, REG_SMOOTH, 16'd2047, 0, 0, 0, 0, 0, 0});
		plan.push_back('{STEP_CFG, REG_UNUSED, 16'hFFFF, 0, 0, 0, 0, 0, 0});
		plan.push_back('{STEP_CFG, REG_WINDOW, 16'd2, 0, 0, 0, 0, 0, 0});
		plan.push_back('{STEP_CFG, REG_SMOOTH, 16'd1024, 0, 0, 0, 0, 0, 0});
		plan.push_back('{STEP_SAMPLE, 0, 0, 32'h0, '1, 32'h0, 0, 0, 0});
		plan.push_back('{STEP_SAMPLE, 0, 0, '1, 32'h0, '1, 0, 0, 0});
		plan.push_back('{STEP_SAMPLE, 0, 0, 32'h50000, 32'h40000, 32'h48000, 0, 0, 0});
		plan.push_back('{STEP_SAMPLE, 0, 0, 32'h52000, 32'h41000, 32'h4A000, 0, 0, 0});

		foreach (plan[i]) begin
			if (plan[i].kind == STEP_CFG) begin
				write_cfg(plan[i].index, plan[i].data);
			end else begin
				typed_word = '{osc: plan[i].osc, fault: plan[i].fault};
				send_sample(plan[i].high, plan[i].low, plan[i].close, plan[i].typed, typed_word);
			end
		end

		// The 64-wide window is slow to warm up, so only a few phases use it.
		base = 32'h00640000;
		nitems = 0;
		for (int seg = 0; nitems < 850; seg++) begin
			case ($urandom_range(9))
				0: win = 0;
				1: win = 64;
				2: win = $urandom_range(65, 127);
				3: win = $urandom_range(9, 20);
				default: win = $urandom_range(1, 8);
			endcase
			case ($urandom_range(7))
				0: sm = 0;
				1: sm = 1;
				2: sm = 1024;
				3: sm = 2047;
				default: sm = $urandom_range(2, 20);
			endcase
			write_cfg(REG_WINDOW, CFG_DATA_W'(win));
			write_cfg(REG_SMOOTH, CFG_DATA_W'(sm));
			idle_pct = modes_idle[seg % 4];
			stall_pct = modes_stall[seg % 4];
			repeat (50) begin
				base = base + 32'($urandom_range(8191)) - 32'd4096;
				c = pick_price(base);
				if ($urandom_range(7) == 0) begin
					h = pick_price(base);
					l = pick_price(base);
				end else begin
					h = c + 32'($urandom_range(32767));
					l = c - 32'($urandom_range(32767));
				end
				send_sample(h, l, c, 0, typed_word);
				nitems++;
			end
		end

		settle();
		if (pending_results.size() == 0 && errors == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end
endmodule

// ----- projected_oscillator.f -----
+incdir+design
design/prjosc_pkg.sv
design/prjosc_ifs.sv
design/prjosc_hist_mem.sv
design/prjosc_div.sv
design/projected_oscillator.sv
bench/testbench.sv
